// ===== hw/rtl/cft_pkg.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer package
// Shared types, character codes, result kinds and register indexes.
// ----------------------------------------------------------------------------
package cft_pkg;

  // Character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2C;

  // Result kinds
  localparam logic [1:0] KIND_CHAR      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_ROW_END   = 2'd2;
  localparam logic [1:0] KIND_BAD_DELIM = 2'd3;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_ROW = 1'd1;
  localparam int unsigned CFG_DATA_W = 8;

  // Result queue geometry
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Input transaction
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_stream;
  } cft_in_t;

  // Output transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] char_out;
    logic       is_header;
    logic       last;
  } cft_out_t;

  // Results of one step: up to two
  typedef struct packed {
    logic [1:0] n;
    cft_out_t   r0;
    cft_out_t   r1;
  } cft_res_t;

endpackage

// ===== hw/rtl/cft_in_stage.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer input register
// Holds one accepted input transaction until the core consumes it.
// ----------------------------------------------------------------------------
module cft_in_stage import cft_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  cft_in_t in_data_i,
  input  logic    take_i,
  output logic    valid_o,
  output cft_in_t data_o
);

  logic    valid_q, valid_d;
  cft_in_t data_q;
  logic    accept;

  // Stall only while a held transaction is not moving on
  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/cft_core.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer core
// Configuration registers, parser state and the per-character step logic.
// ----------------------------------------------------------------------------
module cft_core import cft_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  fire_i,
  input  cft_in_t               item_i,
  output cft_res_t              res_o
);

  logic [7:0] delim_q;
  logic       hdr_row_q;
  logic [7:0] held_char_q, held_char_d;
  logic       held_valid_q, held_valid_d;
  logic       in_quotes_q, in_quotes_d;
  logic       quote_odd_q, quote_odd_d;
  logic       prev_quote_q, prev_quote_d;
  logic       row_fields_q, row_fields_d;
  logic       first_row_q, first_row_d;

  logic       eos;
  logic [7:0] c;
  logic       hdr;
  logic       delim_ok;
  logic       open_pos;
  logic       is_quote;
  logic       quote_odd_n;
  logic       in_quotes_n;
  logic       collapse;
  logic       term;
  logic       row_end;
  cft_res_t   res;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q   <= CH_COMMA;
      hdr_row_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DELIMITER) begin
        delim_q <= cfg_wdata_i[7:0];
      end
      if (cfg_idx_i == CFG_HEADER_ROW) begin
        hdr_row_q <= cfg_wdata_i[0];
      end
    end
  end

  assign eos      = item_i.end_of_stream;
  assign c        = eos ? CH_LF : item_i.char_in;
  assign hdr      = hdr_row_q && first_row_q;
  assign delim_ok = !(delim_q == CH_LF || delim_q == CH_CR || delim_q == CH_NUL ||
                      delim_q == CH_QUOTE);
  assign open_pos = !held_valid_q && !prev_quote_q;
  assign is_quote = (c == CH_QUOTE);
  assign row_end  = (c == CH_LF);

  // Quote run parity and quoted-field tracking
  always_comb begin
    quote_odd_n = quote_odd_q;
    in_quotes_n = in_quotes_q;
    collapse    = 1'b0;
    if (open_pos) begin
      quote_odd_n = quote_odd_q;
    end else if (is_quote) begin
      quote_odd_n = !quote_odd_q;
      in_quotes_n = quote_odd_q;
      collapse    = quote_odd_q;
    end else begin
      quote_odd_n = 1'b0;
    end
  end

  assign term = eos || ((c == delim_q || c == CH_LF) && !in_quotes_n);

  // Step: results and next state
  always_comb begin
    held_char_d  = held_char_q;
    held_valid_d = held_valid_q;
    in_quotes_d  = in_quotes_q;
    quote_odd_d  = quote_odd_q;
    prev_quote_d = prev_quote_q;
    row_fields_d = row_fields_q;
    first_row_d  = first_row_q;
    res          = '0;
    if (!delim_ok) begin
      res.n           = 2'd1;
      res.r0.kind     = KIND_BAD_DELIM;
      res.r0.last     = 1'b1;
    end else if (eos && !held_valid_q && !row_fields_q) begin
      // Empty row at end of stream: drop quote state only
      in_quotes_d  = 1'b0;
      quote_odd_d  = 1'b0;
      prev_quote_d = 1'b0;
    end else if (!eos && c == CH_CR) begin
      // Skip carriage return
      res.n = 2'd0;
    end else if (open_pos && is_quote) begin
      // Opening quote of a field
      in_quotes_d  = 1'b1;
      prev_quote_d = 1'b1;
    end else if (term) begin
      if (held_valid_q && !prev_quote_q) begin
        res.n            = 2'd2;
        res.r0.kind      = KIND_CHAR;
        res.r0.char_out  = held_char_q;
        res.r0.is_header = hdr;
        res.r1.kind      = row_end ? KIND_ROW_END : KIND_FIELD_END;
        res.r1.is_header = hdr;
        res.r1.last      = 1'b1;
      end else begin
        res.n            = 2'd1;
        res.r0.kind      = row_end ? KIND_ROW_END : KIND_FIELD_END;
        res.r0.is_header = hdr;
        res.r0.last      = 1'b1;
      end
      held_valid_d = 1'b0;
      held_char_d  = 8'h00;
      in_quotes_d  = 1'b0;
      prev_quote_d = 1'b0;
      if (row_end) begin
        row_fields_d = 1'b0;
        quote_odd_d  = 1'b0;
        first_row_d  = 1'b0;
      end else begin
        row_fields_d = 1'b1;
        quote_odd_d  = quote_odd_n;
      end
    end else begin
      in_quotes_d = in_quotes_n;
      quote_odd_d = quote_odd_n;
      if (collapse) begin
        held_char_d = CH_QUOTE;
      end else begin
        if (held_valid_q) begin
          res.n            = 2'd1;
          res.r0.kind      = KIND_CHAR;
          res.r0.char_out  = held_char_q;
          res.r0.is_header = hdr;
          res.r0.last      = 1'b1;
        end
        held_char_d  = c;
        held_valid_d = 1'b1;
      end
      prev_quote_d = is_quote;
    end
  end

  // Advance parser state on each consumed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_char_q  <= 8'h00;
      held_valid_q <= 1'b0;
      in_quotes_q  <= 1'b0;
      quote_odd_q  <= 1'b0;
      prev_quote_q <= 1'b0;
      row_fields_q <= 1'b0;
      first_row_q  <= 1'b1;
    end else if (fire_i) begin
      held_char_q  <= held_char_d;
      held_valid_q <= held_valid_d;
      in_quotes_q  <= in_quotes_d;
      quote_odd_q  <= quote_odd_d;
      prev_quote_q <= prev_quote_d;
      row_fields_q <= row_fields_d;
      first_row_q  <= first_row_d;
    end
  end

  assign res_o = res;

`ifndef ASSERT_OFF
  // Only the second of two results closes the step
  a_last_on_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (res.n == 2'd2) |-> res.r1.last && !res.r0.last)
    else $error("two-result step has misplaced last flag");

  // A bad delimiter leaves parser state untouched
  a_bad_delim_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !delim_ok |=> $stable(held_valid_q) && $stable(first_row_q) &&
                            $stable(row_fields_q) && $stable(in_quotes_q))
    else $error("state changed on bad delimiter");

  // A row end leaves the first row
  a_row_end_clears_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && ((res.n == 2'd1 && res.r0.kind == KIND_ROW_END) ||
               (res.n == 2'd2 && res.r1.kind == KIND_ROW_END)) |=> !first_row_q)
    else $error("first row flag survives a row end");
`endif

endmodule

// ===== hw/rtl/cft_res_fifo.sv =====
// ----------------------------------------------------------------------------
// CSV tokenizer result queue
// Takes up to two results per cycle, hands out one per output transaction.
// ----------------------------------------------------------------------------
module cft_res_fifo import cft_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  cft_res_t res_i,
  output logic     room_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output cft_out_t out_data_o
);

  cft_out_t             mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_q, wr_d;
  logic [RES_PTR_W-1:0] rd_q, rd_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]           push_n;
  logic                 pop;

  assign push_n      = fire_i ? res_i.n : 2'd0;
  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  // Room for a full step of results
  assign room_o      = (cnt_q <= RES_CNT_W'(RES_DEPTH - 2));
  assign out_data_o  = mem_q[rd_q];

  // Write results at the tail
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      mem_q[wr_q] <= res_i.r0;
    end
    if (push_n == 2'd2) begin
      mem_q[RES_PTR_W'(wr_q + 1'b1)] <= res_i.r1;
    end
  end

  always_comb begin
    wr_d  = RES_PTR_W'(wr_q + RES_PTR_W'(push_n));
    rd_d  = pop ? RES_PTR_W'(rd_q + 1'b1) : rd_q;
    cnt_d = RES_CNT_W'(cnt_q + RES_CNT_W'(push_n) - RES_CNT_W'(pop));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef ASSERT_OFF
  // Occupancy never passes the depth
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= RES_CNT_W'(RES_DEPTH))
    else $error("result queue overflow");

  // The core only steps when two slots are free
  a_step_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |-> cnt_q <= RES_CNT_W'(RES_DEPTH - 2))
    else $error("step taken without queue room");
`endif

endmodule

// ===== hw/rtl/csv_field_tokenizer.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer
// Splits a CSV character stream into field characters and field/row marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one character or an end-of-stream mark per transaction
//   (in_valid_i / in_stall_o / in_data_i). Output channel: one result per
//   transaction (out_valid_o / out_stall_i / out_data_o); kind tells field
//   character, field end, row end or bad delimiter, last marks the final
//   result caused by an input character.
//   Configuration: write delimiter (index 0) and header flag (index 1) with
//   cfg_we_i while the block is idle.
//   Path: an accepted input is registered in the input stage, steps the core
//   once the result queue has room, and its results are offered from the queue.
//   Throughput: one input per cycle while the result queue has room; the
//   single output port delivers one result per cycle unless the receiver
//   stalls, so a field closed with a held character (two results) needs two output transactions.
//   A four-entry result queue lets input flow while results wait; the input
//   stalls once the input register holds a character and fewer than two queue
//   slots are free.
//   Reset: delimiter ',', header flag off, parser at the start of the first
//   row, queues empty. No clearing pass.
//   Receiver stall: results stay queued and unchanged; input backs up.
// ----------------------------------------------------------------------------
module csv_field_tokenizer import cft_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  cft_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output cft_out_t              out_data_o
);

  logic     item_valid;
  cft_in_t  item;
  logic     room;
  logic     fire;
  cft_res_t res;

  // Step the core when an item is held and the queue has room
  assign fire = item_valid && room;

  cft_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (fire),
    .valid_o    (item_valid),
    .data_o     (item)
  );

  cft_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_o       (res)
  );

  cft_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/csv_field_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// CSV field tokenizer testbench
// A directed table of characters and register writes runs first. Rows whose
// results are obvious (reset state, extremes, bad delimiter) carry typed-in
// expectations; all other rows use the local tokenizer model. Random CSV rows
// follow: mostly well-formed quoted and plain fields, plus some noise. The
// sender runs in bursts and the receiver stalls in patterns of its own.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_tb;
  import cft_pkg::*;

  typedef struct {
    logic                  is_cfg;
    logic [CFG_DATA_W-1:0] delim;
    logic                  hdr;
    cft_in_t               item;
    logic                  typed;
    int                    n;
    cft_out_t              e0;
    cft_out_t              e1;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cft_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  cft_out_t              out_data;

  csv_field_tokenizer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Tokenizer model state and configuration
  logic [7:0] cfg_delim = CH_COMMA;
  logic       cfg_hdr = 1'b0;
  logic [7:0] tk_held = 8'h00;
  logic       tk_held_v = 1'b0;
  logic       tk_quoted = 1'b0;
  logic       tk_run_odd = 1'b0;
  logic       tk_prev_quote = 1'b0;
  logic       tk_row_open = 1'b0;
  logic       tk_first_row = 1'b1;

  int         step_n;
  cft_out_t   step_r [2];
  cft_out_t   token_q [$];
  cft_in_t    row_q [$];
  dir_row_t   dir_tab [$];

  int         errors = 0;
  int         n_checked = 0;
  int         burst_left = 0;
  logic       gaps_on = 1'b1;
  logic       hold_req = 1'b0;
  logic       hold_done = 1'b0;

  function automatic cft_out_t rs(input logic [1:0] kind, input logic [7:0] ch,
                                  input logic hdr, input logic lst);
    return cft_out_t'{kind: kind, char_out: ch, is_header: hdr, last: lst};
  endfunction

  function automatic dir_row_t dr_chk(input logic [7:0] ch, input logic eos, input int n,
                                      input cft_out_t e0, input cft_out_t e1);
    dir_row_t row;
    row.is_cfg = 1'b0;
    row.delim  = '0;
    row.hdr    = 1'b0;
    row.item   = cft_in_t'{char_in: ch, end_of_stream: eos};
    row.typed  = 1'b1;
    row.n      = n;
    row.e0     = e0;
    row.e1     = e1;
    return row;
  endfunction

  function automatic dir_row_t dr(input logic [7:0] ch, input logic eos);
    dir_row_t row;
    row = dr_chk(ch, eos, 0, '0, '0);
    row.typed = 1'b0;
    return row;
  endfunction

  function automatic dir_row_t dr_cfg(input logic [7:0] d, input logic h);
    dir_row_t row;
    row = dr_chk(8'h00, 1'b0, 0, '0, '0);
    row.is_cfg = 1'b1;
    row.delim  = d;
    row.hdr    = h;
    return row;
  endfunction

  task automatic report(input string msg);
    if (errors < 40) $display("mismatch at result %0d: %s", n_checked, msg);
    errors++;
  endtask

  // Advance the model by one character and collect its tokens in step_r
  task automatic tokenize(input cft_in_t it);
    logic       eos;
    logic [7:0] c;
    logic       hdr;
    logic       collapse;
    logic       delim_bad;
    eos       = it.end_of_stream;
    c         = eos ? CH_LF : it.char_in;
    hdr       = cfg_hdr & tk_first_row;
    collapse  = 1'b0;
    delim_bad = (cfg_delim == CH_LF) || (cfg_delim == CH_CR) ||
                (cfg_delim == CH_NUL) || (cfg_delim == CH_QUOTE);
    step_n    = 0;
    if (delim_bad) begin
      step_r[0] = rs(KIND_BAD_DELIM, 8'h00, 1'b0, 1'b0);
      step_n = 1;
    end else if (eos && !tk_held_v && !tk_row_open) begin
      // end on an empty row: drop quote state, no tokens
      tk_quoted     = 1'b0;
      tk_run_odd    = 1'b0;
      tk_prev_quote = 1'b0;
    end else if (!eos && c == CH_CR) begin
      // skip carriage return
    end else if (!tk_held_v && !tk_prev_quote && c == CH_QUOTE) begin
      // open a quoted field
      tk_quoted     = 1'b1;
      tk_prev_quote = 1'b1;
    end else begin
      if (tk_held_v || tk_prev_quote) begin
        if (c == CH_QUOTE) begin
          tk_run_odd = !tk_run_odd;
          tk_quoted  = !tk_run_odd;
          collapse   = tk_quoted;
        end else begin
          tk_run_odd = 1'b0;
        end
      end
      if (eos || ((c == cfg_delim || c == CH_LF) && !tk_quoted)) begin
        // close the field; a held closing quote is dropped
        if (tk_held_v && !tk_prev_quote) begin
          step_r[step_n] = rs(KIND_CHAR, tk_held, hdr, 1'b0);
          step_n++;
        end
        step_r[step_n] = rs((c == CH_LF) ? KIND_ROW_END : KIND_FIELD_END, 8'h00, hdr, 1'b0);
        step_n++;
        tk_held_v     = 1'b0;
        tk_held       = 8'h00;
        tk_quoted     = 1'b0;
        tk_prev_quote = 1'b0;
        if (c == CH_LF) begin
          tk_row_open  = 1'b0;
          tk_run_odd   = 1'b0;
          tk_first_row = 1'b0;
        end else begin
          tk_row_open = 1'b1;
        end
      end else begin
        if (collapse) begin
          tk_held = CH_QUOTE;
        end else begin
          if (tk_held_v) begin
            step_r[step_n] = rs(KIND_CHAR, tk_held, hdr, 1'b0);
            step_n++;
          end
          tk_held   = c;
          tk_held_v = 1'b1;
        end
        tk_prev_quote = (c == CH_QUOTE);
      end
    end
    if (step_n > 0) step_r[step_n-1].last = 1'b1;
  endtask

  // Offer one character, wait for the transaction, queue its tokens
  task automatic send_item(input cft_in_t it, input logic typed, input int n,
                           input cft_out_t e0, input cft_out_t e1);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    tokenize(it);
    if (typed) begin
      step_n    = n;
      step_r[0] = e0;
      step_r[1] = e1;
    end
    for (int k = 0; k < step_n; k++) token_q.push_back(step_r[k]);
  endtask

  // Hold input until every expected token is out and the pipe is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] d, input logic h);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DELIMITER;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_idx   <= CFG_HEADER_ROW;
    cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, h};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_delim = d;
    cfg_hdr   = h;
  endtask

  task automatic add(input logic [7:0] ch, input logic eos);
    row_q.push_back(cft_in_t'{char_in: (eos ? 8'($urandom_range(0, 255)) : ch),
                              end_of_stream: eos});
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == cfg_delim || c == CH_QUOTE || c == CH_LF || c == CH_CR);
    return c;
  endfunction

  // Build one random row: mostly well-formed fields, sometimes noise
  task automatic build_row();
    int nf;
    int r;
    row_q.delete();
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 6)) begin
        r = $urandom_range(0, 9);
        case (r)
          0:       add(CH_QUOTE, 1'b0);
          1:       add(cfg_delim, 1'b0);
          2:       add(CH_LF, 1'b0);
          3:       add(CH_CR, 1'b0);
          4:       add(8'h00, 1'b1);
          default: add(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end
    end else begin
      nf = $urandom_range(1, 4);
      for (int f = 0; f < nf; f++) begin
        if ($urandom_range(0, 99) < 40) begin
          add(CH_QUOTE, 1'b0);
          repeat ($urandom_range(0, 4)) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
              add(plain_char(), 1'b0);
            end else if (r < 70) begin
              add(CH_QUOTE, 1'b0);
              add(CH_QUOTE, 1'b0);
            end else if (r < 82) begin
              add(cfg_delim, 1'b0);
            end else if (r < 92) begin
              add(CH_LF, 1'b0);
            end else begin
              add(CH_CR, 1'b0);
            end
          end
          add(CH_QUOTE, 1'b0);
          // stray character after the closing quote
          if ($urandom_range(0, 99) < 5) add(plain_char(), 1'b0);
        end else begin
          repeat ($urandom_range(0, 5)) add(plain_char(), 1'b0);
        end
        if (f < nf - 1) add(cfg_delim, 1'b0);
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add(CH_LF, 1'b0);
      end else if (r < 85) begin
        add(CH_CR, 1'b0);
        add(CH_LF, 1'b0);
      end else begin
        add(8'h00, 1'b1);
      end
    end
  endtask

  // Receiver: stall patterns per segment, one long hold-off on request
  initial begin
    int pct;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (120) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0:       pct = 0;
          1:       pct = 25;
          2:       pct = 50;
          default: pct = 85;
        endcase
        repeat ($urandom_range(10, 120)) begin
          if (hold_req && !hold_done) break;
          out_stall <= ($urandom_range(0, 99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  // Compare each output transaction with the oldest expected token
  always @(posedge clk) begin : chk
    cft_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (token_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d char %02h", out_data.kind,
                         out_data.char_out));
      end else begin
        want = token_q.pop_front();
        if (out_data.kind !== want.kind)
          report($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
        if (out_data.char_out !== want.char_out)
          report($sformatf("char_out %02h, want %02h", out_data.char_out, want.char_out));
        if (out_data.is_header !== want.is_header)
          report($sformatf("is_header %b, want %b", out_data.is_header, want.is_header));
        if (out_data.last !== want.last)
          report($sformatf("last %b, want %b", out_data.last, want.last));
      end
      n_checked++;
    end
  end

  initial begin
    int         cnt;
    int         target;
    logic [7:0] d;

    // after reset: plain field, default delimiter, no header
    dir_tab.push_back(dr_chk(8'h61, 1'b0, 0, '0, '0));
    dir_tab.push_back(dr_chk(CH_COMMA, 1'b0, 2, rs(KIND_CHAR, 8'h61, 1'b0, 1'b0),
                             rs(KIND_FIELD_END, 8'h00, 1'b0, 1'b1)));
    // rest of the first row as header: quoted field with doubled quotes
    dir_tab.push_back(dr_cfg(CH_COMMA, 1'b1));
    dir_tab.push_back(dr(CH_QUOTE, 1'b0));
    dir_tab.push_back(dr(8'h78, 1'b0));
    dir_tab.push_back(dr(CH_QUOTE, 1'b0));
    dir_tab.push_back(dr(CH_QUOTE, 1'b0));
    dir_tab.push_back(dr(CH_QUOTE, 1'b0));
    dir_tab.push_back(dr(CH_CR, 1'b0));
    dir_tab.push_back(dr(CH_LF, 1'b0));
    // NUL as data, 0xFF as data, end of stream ends the row
    dir_tab.push_back(dr_chk(CH_NUL, 1'b0, 0, '0, '0));
    dir_tab.push_back(dr_chk(8'hFF, 1'b0, 1, rs(KIND_CHAR, 8'h00, 1'b0, 1'b1), '0));
    dir_tab.push_back(dr_chk(CH_COMMA, 1'b1, 2, rs(KIND_CHAR, 8'hFF, 1'b0, 1'b0),
                             rs(KIND_ROW_END, 8'h00, 1'b0, 1'b1)));
    // end on an empty row, then just after an opening quote in the first field
    dir_tab.push_back(dr_chk(8'hFF, 1'b1, 0, '0, '0));
    dir_tab.push_back(dr(CH_QUOTE, 1'b0));
    dir_tab.push_back(dr_chk(8'h00, 1'b1, 0, '0, '0));
    // end just after an opening quote in a later field
    dir_tab.push_back(dr_chk(CH_COMMA, 1'b0, 1, rs(KIND_FIELD_END, 8'h00, 1'b0, 1'b1), '0));
    dir_tab.push_back(dr(CH_QUOTE, 1'b0));
    dir_tab.push_back(dr_chk(8'h00, 1'b1, 1, rs(KIND_ROW_END, 8'h00, 1'b0, 1'b1), '0));
    // end inside quotes, with a newline inside the field
    dir_tab.push_back(dr(CH_QUOTE, 1'b0));
    dir_tab.push_back(dr(8'h71, 1'b0));
    dir_tab.push_back(dr(CH_LF, 1'b0));
    dir_tab.push_back(dr(8'h00, 1'b1));
    // invalid delimiters
    dir_tab.push_back(dr_cfg(CH_CR, 1'b1));
    dir_tab.push_back(dr_chk(8'h61, 1'b0, 1, rs(KIND_BAD_DELIM, 8'h00, 1'b0, 1'b1), '0));
    dir_tab.push_back(dr_cfg(CH_NUL, 1'b1));
    dir_tab.push_back(dr_chk(8'h00, 1'b1, 1, rs(KIND_BAD_DELIM, 8'h00, 1'b0, 1'b1), '0));
    dir_tab.push_back(dr_cfg(CH_QUOTE, 1'b0));
    dir_tab.push_back(dr_chk(CH_QUOTE, 1'b0, 1, rs(KIND_BAD_DELIM, 8'h00, 1'b0, 1'b1), '0));
    dir_tab.push_back(dr_cfg(CH_LF, 1'b0));
    dir_tab.push_back(dr_chk(CH_LF, 1'b0, 1, rs(KIND_BAD_DELIM, 8'h00, 1'b0, 1'b1), '0));
    // top delimiter value
    dir_tab.push_back(dr_cfg(8'hFF, 1'b0));
    dir_tab.push_back(dr_chk(8'hFF, 1'b0, 1, rs(KIND_FIELD_END, 8'h00, 1'b0, 1'b1), '0));
    dir_tab.push_back(dr_chk(8'hFF, 1'b1, 1, rs(KIND_ROW_END, 8'h00, 1'b0, 1'b1), '0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        settle();
        set_config(dir_tab[i].delim, dir_tab[i].hdr);
      end else begin
        send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].n, dir_tab[i].e0,
                  dir_tab[i].e1);
      end
    end

    // Random phases, one setting each
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph)
        0: d = CH_COMMA;
        1: d = 8'h3B;
        2: d = 8'h09;
        3: d = 8'hFF;
        4: begin
          case ($urandom_range(0, 3))
            0:       d = CH_NUL;
            1:       d = CH_CR;
            2:       d = CH_LF;
            default: d = CH_QUOTE;
          endcase
        end
        5: d = 8'h01;
        6: d = 8'h7C;
        default: d = 8'($urandom_range(1, 255));
      endcase
      set_config(d, ph[0]);
      gaps_on = (ph == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
      if (ph == 1) hold_req = 1'b1;
      target = (ph == 4) ? 30 : 175;
      cnt = 0;
      while (cnt < target) begin
        build_row();
        foreach (row_q[j]) send_item(row_q[j], 1'b0, 0, '0, '0);
        cnt += row_q.size();
      end
    end

    settle();
    if (token_q.size() != 0) report($sformatf("%0d tokens never arrived", token_q.size()));
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
